>>> sv/qoie_pkg.sv
// Shared types, opcodes and segment sequencing for the QOI image encoder.
package qoie_pkg;

  localparam int IDX_W = 6;

  localparam logic [5:0] RUN_MAX  = 6'd62;
  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  localparam logic [3:0] HDR_LAST = 4'd13;
  localparam logic [3:0] END_LAST = 4'd7;

  typedef enum logic [1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_CHANNELS,
    CFG_SPACE
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
    logic [2:0]  channels;
    logic [7:0]  space;
  } cfg_t;

  // Byte groups that one pixel produces; op_b[0] leaves first.
  typedef struct packed {
    logic            hdr;
    logic            run_v;
    logic [7:0]      run_byte;
    logic [2:0]      op_len;
    logic [4:0][7:0] op_b;
    logic            endm;
  } rec_t;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_HDR,
    SEG_RUN,
    SEG_OP,
    SEG_END
  } seg_t;

  // Segment that follows seg within rec; SEG_IDLE from SEG_IDLE gives the first one.
  function automatic seg_t next_seg(rec_t rec, seg_t seg);
    seg_t res;
    res = SEG_IDLE;
    case (seg)
      SEG_IDLE: begin
        if (rec.hdr) res = SEG_HDR;
        else if (rec.run_v) res = SEG_RUN;
        else if (rec.op_len != 3'd0) res = SEG_OP;
        else if (rec.endm) res = SEG_END;
      end
      SEG_HDR: begin
        if (rec.run_v) res = SEG_RUN;
        else if (rec.op_len != 3'd0) res = SEG_OP;
        else if (rec.endm) res = SEG_END;
      end
      SEG_RUN: begin
        if (rec.op_len != 3'd0) res = SEG_OP;
        else if (rec.endm) res = SEG_END;
      end
      SEG_OP: begin
        if (rec.endm) res = SEG_END;
      end
      default: res = SEG_IDLE;
    endcase
    return res;
  endfunction

endpackage

>>> sv/qoie_front.sv
// Pixel front end: cache lookup, op selection and run tracking, one pixel per cycle unless stalled.
module qoie_front (
  input  logic          clk,
  input  logic          rst,
  input  qoie_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  logic [7:0]    alpha,
  input  logic          final_pixel,
  output logic          rec_valid,
  output qoie_pkg::rec_t rec,
  input  logic          rec_full
);

  logic [31:0] cache_mem [64];
  logic [63:0] valid_bits;
  logic [31:0] mem_q;
  logic        fwd_hit;
  logic [31:0] fwd_px;

  logic        s1_valid;
  logic [31:0] s1_px;
  logic        s1_last;
  logic [qoie_pkg::IDX_W-1:0] s1_idx;

  logic [31:0] prev_px;
  logic [5:0]  run_length;
  logic        header_done;
  logic [5:0]  run_next;

  logic [7:0]  a_in;
  logic [31:0] px_in;
  logic [12:0] hsum;
  logic [qoie_pkg::IDX_W-1:0] idx_in;
  logic        in_accept;
  logic        s1_adv;
  logic        s1_fire;
  logic        same;
  logic        cache_write;
  logic [31:0] entry;
  logic [5:0]  run_inc;

  logic signed [7:0] dr, dg, db;
  logic signed [8:0] drg, dbg;

  // stage 0: alpha forcing and hash
  always_comb begin
    a_in   = (cfg.channels == 3'd4) ? alpha : 8'hFF;
    px_in  = {red, green, blue, a_in};
    hsum   = 13'(red) * 13'd3 + 13'(green) * 13'd5 + 13'(blue) * 13'd7 + 13'(a_in) * 13'd11;
    idx_in = hsum[qoie_pkg::IDX_W-1:0];
  end

  assign s1_adv    = !s1_valid || !rec_valid || !rec_full;
  assign s1_fire   = s1_valid && s1_adv;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign same        = (s1_px == prev_px);
  assign cache_write = s1_fire && !same;
  assign entry       = fwd_hit ? fwd_px : (valid_bits[s1_idx] ? mem_q : 32'h0);
  assign run_inc     = run_length + 6'd1;

  assign dr  = s1_px[31:24] - prev_px[31:24];
  assign dg  = s1_px[23:16] - prev_px[23:16];
  assign db  = s1_px[15:8]  - prev_px[15:8];
  assign drg = 9'(dr) - 9'(dg);
  assign dbg = 9'(db) - 9'(dg);

  always_comb begin
    rec       = '0;
    rec.hdr   = !header_done;
    rec.endm  = s1_last;
    run_next  = run_length;
    if (same) begin
      run_next = run_inc;
      if (run_inc == qoie_pkg::RUN_MAX) begin
        rec.run_v    = 1'b1;
        rec.run_byte = qoie_pkg::OP_RUN | {2'b00, qoie_pkg::RUN_MAX - 6'd1};
        run_next     = 6'd0;
      end
    end else begin
      if (run_length != 6'd0) begin
        rec.run_v    = 1'b1;
        rec.run_byte = qoie_pkg::OP_RUN | {2'b00, run_length - 6'd1};
        run_next     = 6'd0;
      end
      if (entry == s1_px) begin
        rec.op_len  = 3'd1;
        rec.op_b[0] = qoie_pkg::OP_INDEX | {2'b00, s1_idx};
      end else if (s1_px[7:0] == prev_px[7:0]) begin
        if (dr >= -8'sd2 && dr <= 8'sd1 && dg >= -8'sd2 && dg <= 8'sd1 &&
            db >= -8'sd2 && db <= 8'sd1) begin
          rec.op_len  = 3'd1;
          rec.op_b[0] = qoie_pkg::OP_DIFF | {2'b00, 2'(dr[1:0] + 2'd2),
                        2'(dg[1:0] + 2'd2), 2'(db[1:0] + 2'd2)};
        end else if (dg >= -8'sd32 && dg <= 8'sd31 && drg >= -9'sd8 && drg <= 9'sd7 &&
                     dbg >= -9'sd8 && dbg <= 9'sd7) begin
          rec.op_len  = 3'd2;
          rec.op_b[0] = qoie_pkg::OP_LUMA | {2'b00, 6'(dg[5:0] + 6'd32)};
          rec.op_b[1] = {4'(drg[3:0] + 4'd8), 4'(dbg[3:0] + 4'd8)};
        end else begin
          rec.op_len  = 3'd4;
          rec.op_b[0] = qoie_pkg::OP_RGB;
          rec.op_b[1] = s1_px[31:24];
          rec.op_b[2] = s1_px[23:16];
          rec.op_b[3] = s1_px[15:8];
        end
      end else begin
        rec.op_len  = 3'd5;
        rec.op_b[0] = qoie_pkg::OP_RGBA;
        rec.op_b[1] = s1_px[31:24];
        rec.op_b[2] = s1_px[23:16];
        rec.op_b[3] = s1_px[15:8];
        rec.op_b[4] = s1_px[7:0];
      end
    end
    if (s1_last) begin
      if (run_next != 6'd0) begin
        rec.run_v    = 1'b1;
        rec.run_byte = qoie_pkg::OP_RUN | {2'b00, run_next - 6'd1};
      end
      run_next = 6'd0;
    end
  end

  assign rec_valid = s1_valid && (rec.hdr || rec.run_v || rec.op_len != 3'd0 || rec.endm);

  // cache storage and registered read
  always_ff @(posedge clk) begin
    if (cache_write) cache_mem[s1_idx] <= s1_px;
    if (in_accept) begin
      mem_q   <= cache_mem[idx_in];
      fwd_px  <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      fwd_hit     <= 1'b0;
      valid_bits  <= '0;
      prev_px     <= 32'h0000_00FF;
      run_length  <= 6'd0;
      header_done <= 1'b0;
    end else begin
      if (in_accept) begin
        // pick up the write that lands on the same edge as this read
        fwd_hit <= cache_write && !s1_last && (s1_idx == idx_in);
      end
      if (s1_adv) s1_valid <= in_accept;
      if (s1_fire) begin
        if (s1_last) begin
          valid_bits  <= '0;
          prev_px     <= 32'h0000_00FF;
          run_length  <= 6'd0;
          header_done <= 1'b0;
        end else begin
          if (!same) begin
            valid_bits[s1_idx] <= 1'b1;
            prev_px            <= s1_px;
          end
          run_length  <= run_next;
          header_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px   <= px_in;
      s1_last <= final_pixel;
      s1_idx  <= idx_in;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (!header_done && run_length == 6'd0 && valid_bits == '0))
    else $error("end of image did not clear encoder state");

endmodule

>>> sv/qoie_queue.sv
// Short record queue between the pixel front end and the byte serializer.
module qoie_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  qoie_pkg::rec_t push_rec,
  output logic           full,
  output logic           head_valid,
  output qoie_pkg::rec_t head_rec,
  input  logic           pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qoie_pkg::rec_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = entries[rd_ptr];
  assign push       = push_valid && !full;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count lost a transfer");

endmodule

>>> sv/qoie_back.sv
// Byte serializer: walks header, run, op and end marker segments of each record.
module qoie_back (
  input  logic           clk,
  input  logic           rst,
  input  qoie_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  qoie_pkg::rec_t q_rec,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     code_byte,
  output logic           item_done
);

  qoie_pkg::seg_t state, state_next;
  qoie_pkg::rec_t cur;
  logic [3:0] cnt, cnt_next;
  logic       emit;
  logic       seg_end;
  logic       rec_end;
  logic [7:0] byte_sel;

  assign emit = (state != qoie_pkg::SEG_IDLE) && (!out_valid || !out_stall);

  always_comb begin
    seg_end  = 1'b0;
    byte_sel = 8'h00;
    case (state)
      qoie_pkg::SEG_HDR: begin
        seg_end = (cnt == qoie_pkg::HDR_LAST);
        case (cnt)
          4'd0:    byte_sel = 8'h71;
          4'd1:    byte_sel = 8'h6F;
          4'd2:    byte_sel = 8'h69;
          4'd3:    byte_sel = 8'h66;
          4'd4:    byte_sel = cfg.width[31:24];
          4'd5:    byte_sel = cfg.width[23:16];
          4'd6:    byte_sel = cfg.width[15:8];
          4'd7:    byte_sel = cfg.width[7:0];
          4'd8:    byte_sel = cfg.height[31:24];
          4'd9:    byte_sel = cfg.height[23:16];
          4'd10:   byte_sel = cfg.height[15:8];
          4'd11:   byte_sel = cfg.height[7:0];
          4'd12:   byte_sel = {5'b00000, cfg.channels};
          default: byte_sel = cfg.space;
        endcase
      end
      qoie_pkg::SEG_RUN: begin
        seg_end  = 1'b1;
        byte_sel = cur.run_byte;
      end
      qoie_pkg::SEG_OP: begin
        seg_end  = (cnt[2:0] == cur.op_len - 3'd1);
        byte_sel = cur.op_b[cnt[2:0]];
      end
      qoie_pkg::SEG_END: begin
        seg_end  = (cnt == qoie_pkg::END_LAST);
        byte_sel = seg_end ? 8'h01 : 8'h00;
      end
      default: begin
        seg_end  = 1'b0;
        byte_sel = 8'h00;
      end
    endcase
  end

  assign rec_end = seg_end && (qoie_pkg::next_seg(cur, state) == qoie_pkg::SEG_IDLE);
  assign pop     = q_valid && ((state == qoie_pkg::SEG_IDLE) || (emit && rec_end));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    if (pop) begin
      state_next = qoie_pkg::next_seg(q_rec, qoie_pkg::SEG_IDLE);
      cnt_next   = 4'd0;
    end else if (emit) begin
      if (seg_end) begin
        state_next = qoie_pkg::next_seg(cur, state);
        cnt_next   = 4'd0;
      end else begin
        cnt_next = cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qoie_pkg::SEG_IDLE;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_rec;
    if (emit) begin
      code_byte <= byte_sel;
      item_done <= rec_end;
    end
  end

  a_op_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == qoie_pkg::SEG_OP) |-> (cnt[2:0] < cur.op_len))
    else $error("op byte index past op length");

  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> ((state == qoie_pkg::SEG_IDLE) || (emit && rec_end)))
    else $error("record loaded while one is still in progress");

endmodule

>>> sv/qoie_image_encoder.sv
// QOI image encoder top level: configuration registers, front end, queue, serializer.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   pixel    in         in_valid / in_stall  red, green, blue, alpha, final_pixel
//   byte     out        out_valid/out_stall  code_byte, item_done
//
// The front end takes one pixel per cycle unless stalled; the cache read is registered.
// Bytes leave one per cycle through the serializer output register while out_stall is low,
// so a pixel's bytes form a burst (header 14, end marker 8, ops 1 to 5);
// the record queue absorbs such bursts until it fills and the front end stalls.
// Reset is synchronous; the color cache uses per-entry valid bits, so no clearing pass.
// A stalled output holds its byte; the queue lets the front end keep working meanwhile.
module qoi_image_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic        final_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  code_byte,
  output logic        item_done
);

  qoie_pkg::cfg_t cfg;
  qoie_pkg::rec_t rec, head_rec;
  logic rec_valid, rec_full, head_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= 32'd0;
      cfg.height   <= 32'd0;
      cfg.channels <= 3'd4;
      cfg.space    <= 8'd0;
    end else if (cfg_write) begin
      case (qoie_pkg::cfg_idx_t'(cfg_index))
        qoie_pkg::CFG_WIDTH:    cfg.width    <= cfg_data;
        qoie_pkg::CFG_HEIGHT:   cfg.height   <= cfg_data;
        qoie_pkg::CFG_CHANNELS: cfg.channels <= cfg_data[2:0];
        qoie_pkg::CFG_SPACE:    cfg.space    <= cfg_data[7:0];
        default:                cfg.space    <= cfg.space;
      endcase
    end
  end

  qoie_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .final_pixel (final_pixel),
    .rec_valid   (rec_valid),
    .rec         (rec),
    .rec_full    (rec_full)
  );

  qoie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (rec_valid),
    .push_rec   (rec),
    .full       (rec_full),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  qoie_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (head_valid),
    .q_rec     (head_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_byte (code_byte),
    .item_done (item_done)
  );

endmodule

>>> test/qoi_image_encoder_tb.sv
// Self-checking testbench for qoi_image_encoder: directed and random pixel images against a QOI byte predictor.
typedef struct packed {
  logic [7:0] code;
  logic       done;
} coded_byte_t;

class qoi_stream_scoreboard;
  logic [31:0] width_reg;
  logic [31:0] height_reg;
  logic [2:0]  chan_reg;
  logic [7:0]  space_reg;
  logic [31:0] prev_px;
  logic [31:0] color_tbl [64];
  logic [5:0]  run_len;
  bit          header_sent;
  coded_byte_t coded_bytes_q [$];
  int          mismatches;

  function new();
    width_reg  = '0;
    height_reg = '0;
    chan_reg   = 3'd4;
    space_reg  = '0;
    mismatches = 0;
    restart_image();
  endfunction

  function void restart_image();
    prev_px = 32'h000000FF;
    foreach (color_tbl[i]) color_tbl[i] = '0;
    run_len = '0;
    header_sent = 1'b0;
  endfunction

  function void set_reg(qoie_pkg::cfg_idx_t idx, logic [31:0] val);
    case (idx)
      qoie_pkg::CFG_WIDTH:    width_reg = val;
      qoie_pkg::CFG_HEIGHT:   height_reg = val;
      qoie_pkg::CFG_CHANNELS: chan_reg = val[2:0];
      qoie_pkg::CFG_SPACE:    space_reg = val[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return coded_bytes_q.size();
  endfunction

  function void add_byte(logic [7:0] b);
    coded_byte_t e;
    e.code = b;
    e.done = 1'b0;
    coded_bytes_q.push_back(e);
  endfunction

  // channel difference taken as a wrapped signed byte
  function int wrap_step(logic [7:0] now, logic [7:0] was);
    logic [7:0] d;
    d = now - was;
    return int'($signed(d));
  endfunction

  function void flush_run();
    if (run_len != 6'd0) begin
      add_byte(qoie_pkg::OP_RUN | {2'b00, run_len - 6'd1});
      run_len = '0;
    end
  endfunction

  function void encode_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a_in,
                             logic fin);
    logic [7:0]  a, pr, pg, pb, pa;
    logic [31:0] px;
    logic [5:0]  slot;
    coded_byte_t tail;
    int          h, dr, dg, db, drg, dbg, first;
    first = coded_bytes_q.size();
    a = (chan_reg == 3'd4) ? a_in : 8'hFF;
    px = {r, g, b, a};
    if (!header_sent) begin
      add_byte("q");
      add_byte("o");
      add_byte("i");
      add_byte("f");
      for (int i = 3; i >= 0; i--) add_byte(width_reg[8*i +: 8]);
      for (int i = 3; i >= 0; i--) add_byte(height_reg[8*i +: 8]);
      add_byte({5'd0, chan_reg});
      add_byte(space_reg);
      header_sent = 1'b1;
    end
    if (px == prev_px) begin
      run_len++;
      if (run_len == qoie_pkg::RUN_MAX) flush_run();
    end else begin
      {pr, pg, pb, pa} = prev_px;
      h = r * 3 + g * 5 + b * 7 + a * 11;
      slot = h[5:0];
      flush_run();
      if (color_tbl[slot] == px) begin
        add_byte(qoie_pkg::OP_INDEX | {2'b00, slot});
      end else if (a == pa) begin
        dr = wrap_step(r, pr);
        dg = wrap_step(g, pg);
        db = wrap_step(b, pb);
        drg = dr - dg;
        dbg = db - dg;
        if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
          add_byte(qoie_pkg::OP_DIFF | 8'((dr + 2) * 16 + (dg + 2) * 4 + (db + 2)));
        end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7 &&
                     dbg >= -8 && dbg <= 7) begin
          add_byte(qoie_pkg::OP_LUMA | 8'(dg + 32));
          add_byte(8'((drg + 8) * 16 + (dbg + 8)));
        end else begin
          add_byte(qoie_pkg::OP_RGB);
          add_byte(r);
          add_byte(g);
          add_byte(b);
        end
      end else begin
        add_byte(qoie_pkg::OP_RGBA);
        add_byte(r);
        add_byte(g);
        add_byte(b);
        add_byte(a);
      end
      color_tbl[slot] = px;
      prev_px = px;
    end
    if (fin) begin
      flush_run();
      // end marker: seven zero bytes, then one
      repeat (7) add_byte(8'h00);
      add_byte(8'h01);
      restart_image();
    end
    if (coded_bytes_q.size() > first) begin
      tail = coded_bytes_q.pop_back();
      tail.done = 1'b1;
      coded_bytes_q.push_back(tail);
    end
  endfunction

  function void note_mismatch(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  function void check_byte(logic [7:0] code, logic done);
    coded_byte_t e;
    if (coded_bytes_q.size() == 0) begin
      note_mismatch($sformatf("unexpected byte %02h item_done %0b", code, done));
      return;
    end
    e = coded_bytes_q.pop_front();
    if (code !== e.code || done !== e.done)
      note_mismatch($sformatf("code_byte exp %02h got %02h, item_done exp %0b got %0b",
                              e.code, code, e.done, done));
  endfunction
endclass

module qoi_image_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 320;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  red, green, blue, alpha;
  logic        final_pixel;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  code_byte;
  logic        item_done;

  qoi_stream_scoreboard board = new();

  int          pixels_sent;
  int          idle_cycles;
  bit          no_idle;
  bit          hold_req;
  logic [7:0]  cur_r, cur_g, cur_b, cur_a;
  logic [31:0] palette [8];

  qoi_image_encoder uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .red(red), .green(green), .blue(blue), .alpha(alpha), .final_pixel(final_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .code_byte(code_byte), .item_done(item_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_cfg(qoie_pkg::cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    board.set_reg(idx, val);
  endtask

  // offer the current pixel and hold it until the transfer
  task automatic push_pixel(logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    red = cur_r;
    green = cur_g;
    blue = cur_b;
    alpha = cur_a;
    final_pixel = fin;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    board.encode_pixel(red, green, blue, alpha, final_pixel);
    pixels_sent++;
  endtask

  task automatic send_rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                           logic fin);
    cur_r = r;
    cur_g = g;
    cur_b = b;
    cur_a = a;
    push_pixel(fin);
  endtask

  task automatic drain_and_pause();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // next pixel, biased toward the small-step and cache-hit codings
  task automatic make_pixel();
    int kind, dg;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      cur_r = cur_r + 8'($urandom_range(0, 3)) - 8'd2;
      cur_g = cur_g + 8'($urandom_range(0, 3)) - 8'd2;
      cur_b = cur_b + 8'($urandom_range(0, 3)) - 8'd2;
    end else if (kind < 55) begin
      dg = int'($urandom_range(0, 63)) - 32;
      cur_g = cur_g + 8'(dg);
      cur_r = cur_r + 8'(dg + int'($urandom_range(0, 15)) - 8);
      cur_b = cur_b + 8'(dg + int'($urandom_range(0, 15)) - 8);
    end else if (kind < 70) begin
      {cur_r, cur_g, cur_b, cur_a} = palette[$urandom_range(0, 7)];
    end else if (kind < 85) begin
      cur_r = 8'($urandom());
      cur_g = 8'($urandom());
      cur_b = 8'($urandom());
    end else begin
      {cur_r, cur_g, cur_b, cur_a} = $urandom();
    end
    palette[$urandom_range(0, 7)] = {cur_r, cur_g, cur_b, cur_a};
  endtask

  task automatic send_image(int len, bit long_run);
    int n, reps;
    if (long_run) begin
      make_pixel();
      push_pixel(1'b0);
      repeat ($urandom_range(60, 66)) push_pixel(1'b0);
    end
    n = 0;
    while (n < len) begin
      if ($urandom_range(0, 4) == 0) begin
        reps = $urandom_range(1, 4);
      end else begin
        make_pixel();
        reps = 1;
      end
      if (reps > len - n) reps = len - n;
      repeat (reps) begin
        n++;
        push_pixel(n == len);
      end
    end
  endtask

  task automatic program_phase(int p);
    logic [31:0] v;
    if (p == 0 || $urandom_range(0, 3) != 0) begin
      case (p % 3)
        0: v = 32'h0;
        1: v = 32'hFFFF_FFFF;
        default: v = $urandom();
      endcase
      write_cfg(qoie_pkg::CFG_WIDTH, v);
    end
    if (p == 0 || $urandom_range(0, 3) != 0) begin
      case ((p + 1) % 3)
        0: v = 32'h0;
        1: v = 32'hFFFF_FFFF;
        default: v = $urandom();
      endcase
      write_cfg(qoie_pkg::CFG_HEIGHT, v);
    end
    case (p % 5)
      0, 3: v = 32'd3;
      1, 4: v = 32'd4;
      default: v = $urandom_range(0, 7);
    endcase
    // junk above the field must be dropped
    if (p % 2 == 1) v = v | ($urandom() & ~32'h7);
    write_cfg(qoie_pkg::CFG_CHANNELS, v);
    if (p == 0 || $urandom_range(0, 2) != 0) begin
      case (p % 4)
        0: v = 32'd0;
        1: v = 32'd255;
        2: v = 32'd1;
        default: v = $urandom_range(0, 255);
      endcase
      if (p % 2 == 1) v = v | ($urandom() & ~32'hFF);
      write_cfg(qoie_pkg::CFG_SPACE, v);
    end
  endtask

  // output side: random stall per byte, plus one long hold-off on request
  initial begin
    int stall;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      board.check_byte(code_byte, item_done);
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("qoi_image_encoder regression: fail");
      $finish;
    end
  end

  initial begin
    int phase;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = qoie_pkg::CFG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    alpha = '0;
    final_pixel = 1'b0;
    pixels_sent = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    foreach (palette[i]) palette[i] = $urandom();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: runs, zero pixel hitting the empty cache, every op, run at end
    send_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_rgba(8'd1, 8'd0, 8'd255, 8'd0, 1'b0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
    send_rgba(8'd37, 8'd30, 8'd22, 8'd0, 1'b0);
    send_rgba(8'd253, 8'd254, 8'd253, 8'd0, 1'b0);
    send_rgba(8'd128, 8'd127, 8'd1, 8'd0, 1'b0);
    send_rgba(8'd170, 8'd85, 8'd240, 8'd255, 1'b0);
    send_rgba(8'd1, 8'd0, 8'd255, 8'd0, 1'b0);
    send_rgba(8'd1, 8'd0, 8'd255, 8'd0, 1'b0);
    send_rgba(8'd1, 8'd0, 8'd255, 8'd0, 1'b0);
    send_rgba(8'd1, 8'd0, 8'd255, 8'd0, 1'b1);
    drain_and_pause();

    // one-pixel image with the longest byte burst
    write_cfg(qoie_pkg::CFG_WIDTH, 32'hFFFF_FFFF);
    write_cfg(qoie_pkg::CFG_HEIGHT, 32'h0);
    write_cfg(qoie_pkg::CFG_CHANNELS, 32'd4);
    write_cfg(qoie_pkg::CFG_SPACE, 32'd255);
    send_rgba(8'h12, 8'h34, 8'h56, 8'h00, 1'b1);
    drain_and_pause();

    // three channels: alpha input ignored
    write_cfg(qoie_pkg::CFG_WIDTH, 32'd1);
    write_cfg(qoie_pkg::CFG_HEIGHT, 32'hFFFF_FFFF);
    write_cfg(qoie_pkg::CFG_CHANNELS, 32'd3);
    write_cfg(qoie_pkg::CFG_SPACE, 32'd1);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_rgba(8'd5, 8'd5, 8'd5, 8'h80, 1'b0);
    send_rgba(8'd5, 8'd5, 8'd5, 8'h11, 1'b0);
    send_rgba(8'd6, 8'd4, 8'd5, 8'd0, 1'b1);
    drain_and_pause();

    // out-of-range channel count: alpha input ignored, as with three channels
    write_cfg(qoie_pkg::CFG_CHANNELS, 32'd7);
    send_rgba(8'd9, 8'd9, 8'd9, 8'd0, 1'b0);
    send_rgba(8'd9, 8'd9, 8'd9, 8'd77, 1'b1);

    phase = 0;
    while (pixels_sent < ITEM_TARGET) begin
      drain_and_pause();
      program_phase(phase);
      no_idle = (phase % 4 == 3);
      if (phase == 2) begin
        // stall the output for a long stretch while pixels keep coming
        no_idle = 1'b1;
        hold_req = 1'b1;
        send_image(30, 1'b0);
      end else begin
        send_image($urandom_range(1, 24), $urandom_range(0, 5) == 0);
      end
      phase++;
    end

    drain_and_pause();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("qoi_image_encoder regression: pass");
    end else begin
      $display("qoi_image_encoder regression: fail");
    end
    $finish;
  end

endmodule
